[rtl/hrds_pkg.sv]
// Shared constants and types for the HID report descriptor scan unit.
`timescale 1ns / 1ps

package hrds_pkg;

   localparam int DEPTH_BITS_DEFAULT = 8;

   localparam logic [7:0] LONG_PREFIX    = 8'hFE;
   localparam logic [7:0] TAG_MASK       = 8'hFC;
   localparam logic [7:0] TAG_COLLECTION = 8'hA0;
   localparam logic [7:0] TAG_END_COLL   = 8'hC0;
   localparam logic [7:0] TAG_REPORT_ID  = 8'h84;
   localparam logic [7:0] TAG_USAGE_PAGE = 8'h04;
   localparam logic [7:0] TAG_USAGE      = 8'h08;

   localparam int RSP_DATA_BITS = 40;

   typedef struct packed {
      logic [15:0] top_page;
      logic [15:0] usage;
      logic        has_report_ids;
      logic        truncated;
   } hrds_result_type;

endpackage

[rtl/hrds_parse_core.sv]
// Byte-level item parser: phase, item assembly, depth and captured values.
`timescale 1ns / 1ps

module hrds_parse_core #(
   parameter int DEPTH_BITS = hrds_pkg::DEPTH_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               data_byte,
   input  logic                     last,
   output hrds_pkg::hrds_result_type result
);

   typedef enum logic [1:0] {
      PH_PREFIX    = 2'd0,
      PH_DATA      = 2'd1,
      PH_LONG_LEN  = 2'd2,
      PH_LONG_SKIP = 2'd3
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [8:0]            bytes_left_ff, bytes_left_in;
   logic [7:0]            item_tag_ff, item_tag_in;
   logic [2:0]            item_size_ff, item_size_in;
   logic [15:0]           item_value_ff, item_value_in;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic [15:0]           top_page_ff, top_page_in;
   logic [15:0]           usage_ff, usage_in;
   logic                  report_id_ff, report_id_in;

   logic       do_apply;
   logic [2:0] data_index;

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      item_tag_in   = item_tag_ff;
      item_size_in  = item_size_ff;
      item_value_in = item_value_ff;
      depth_in      = depth_ff;
      top_page_in   = top_page_ff;
      usage_in      = usage_ff;
      report_id_in  = report_id_ff;
      do_apply      = 1'b0;
      data_index    = item_size_ff - bytes_left_ff[2:0];

      unique case (phase_ff)
         PH_PREFIX: begin
            if (data_byte == hrds_pkg::LONG_PREFIX) begin
               phase_in = PH_LONG_LEN;
            end else begin
               // size code 3 means four data bytes
               item_size_in  = (data_byte[1:0] == 2'd3) ? 3'd4 : {1'b0, data_byte[1:0]};
               item_tag_in   = data_byte & hrds_pkg::TAG_MASK;
               item_value_in = 16'd0;
               if (data_byte[1:0] == 2'd0) begin
                  do_apply = 1'b1;
               end else begin
                  bytes_left_in = {6'd0, item_size_in};
                  phase_in      = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            // only the first two data bytes land in the kept 16 bits
            if (data_index == 3'd0) begin
               item_value_in = {item_value_ff[15:8], item_value_ff[7:0] | data_byte};
            end else if (data_index == 3'd1) begin
               item_value_in = {item_value_ff[15:8] | data_byte, item_value_ff[7:0]};
            end
            if (bytes_left_ff != 9'd0) begin
               bytes_left_in = bytes_left_ff - 9'd1;
            end
            if (bytes_left_in == 9'd0) begin
               do_apply = 1'b1;
               phase_in = PH_PREFIX;
            end
         end
         PH_LONG_LEN: begin
            // data bytes given by the length byte, plus the tag byte, still to skip
            bytes_left_in = {1'b0, data_byte} + 9'd1;
            phase_in      = PH_LONG_SKIP;
         end
         PH_LONG_SKIP: begin
            if (bytes_left_ff != 9'd0) begin
               bytes_left_in = bytes_left_ff - 9'd1;
            end
            if (bytes_left_in == 9'd0) begin
               phase_in = PH_PREFIX;
            end
         end
         default: begin
            phase_in = PH_PREFIX;
         end
      endcase

      if (do_apply) begin
         unique case (item_tag_in)
            hrds_pkg::TAG_COLLECTION: depth_in = depth_ff + DEPTH_BITS'(1);
            hrds_pkg::TAG_END_COLL:   depth_in = depth_ff - DEPTH_BITS'(1);
            hrds_pkg::TAG_REPORT_ID:  report_id_in = 1'b1;
            hrds_pkg::TAG_USAGE_PAGE: begin
               if (depth_ff == '0) top_page_in = item_value_in;
            end
            hrds_pkg::TAG_USAGE: begin
               if (depth_ff == '0) usage_in = item_value_in;
            end
            default: begin
            end
         endcase
      end

      result.top_page       = top_page_in;
      result.usage          = usage_in;
      result.has_report_ids = report_id_in;
      result.truncated      = (phase_in == PH_DATA);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_PREFIX;
         bytes_left_ff <= 9'd0;
         item_tag_ff   <= 8'd0;
         item_size_ff  <= 3'd0;
         item_value_ff <= 16'd0;
         depth_ff      <= '0;
         top_page_ff   <= 16'd0;
         usage_ff      <= 16'd0;
         report_id_ff  <= 1'b0;
      end else if (step) begin
         if (last) begin
            // descriptor done: start the next one from scratch
            phase_ff      <= PH_PREFIX;
            bytes_left_ff <= 9'd0;
            item_tag_ff   <= 8'd0;
            item_size_ff  <= 3'd0;
            item_value_ff <= 16'd0;
            depth_ff      <= '0;
            top_page_ff   <= 16'd0;
            usage_ff      <= 16'd0;
            report_id_ff  <= 1'b0;
         end else begin
            phase_ff      <= phase_in;
            bytes_left_ff <= bytes_left_in;
            item_tag_ff   <= item_tag_in;
            item_size_ff  <= item_size_in;
            item_value_ff <= item_value_in;
            depth_ff      <= depth_in;
            top_page_ff   <= top_page_in;
            usage_ff      <= usage_in;
            report_id_ff  <= report_id_in;
         end
      end
   end

endmodule

[rtl/hid_report_descriptor_scan_unit.sv]
// Top level of the HID report descriptor scan unit.
// Accepts one descriptor byte per cycle while the input is not stalled, with
// tlast on the final byte, and returns one summary item per descriptor:
// top-level usage page and usage, a numbered-reports flag and a flag for a
// short item cut off by the end. Each byte is taken into an input register
// and parsed in the next cycle, later for a last byte held by the stall; the
// summary waits in a result register until taken. The input side keeps taking
// bytes while a summary waits, and stalls only when a last byte is ready to
// parse and the previous summary has not yet been taken. Long items are
// skipped; DEPTH_BITS sets the width of the wrapping collection depth counter.
`timescale 1ns / 1ps

module hid_report_descriptor_scan_unit #(
   parameter int DEPTH_BITS = hrds_pkg::DEPTH_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // data_byte
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // top_page[15:0], usage[31:16], has_report_ids[32], truncated[33], zero fill
   output logic [hrds_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   hrds_pkg::hrds_result_type rsp_data_ff, core_result;

   logic out_free;
   logic advance;
   logic req_accept;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   hrds_parse_core #(
      .DEPTH_BITS (DEPTH_BITS)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .last      (in_last_ff),
      .result    (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_accept) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && in_last_ff) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff.truncated, rsp_data_ff.has_report_ids,
                        rsp_data_ff.usage, rsp_data_ff.top_page};

endmodule

[rtl/hrds_checker.sv]
// Port-level checks for the HID report descriptor scan unit, bound to the top level.
`timescale 1ns / 1ps

module hrds_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [hrds_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   // a waiting summary holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("summary item dropped or changed while stalled");

   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("summary valid right after reset");

   // input stalls only behind a summary that is itself stalled
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output back-pressure");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[hrds_pkg::RSP_DATA_BITS-1:34] == '0)
      else $error("summary fill bits not zero");

   // an input stall lasts only while the output is held off
   assert property (@(posedge clock) disable iff (reset)
      !req_tready && req_tvalid && rsp_tready |=> req_tready)
      else $error("input stall outlived output back-pressure");

endmodule

bind hid_report_descriptor_scan_unit hrds_checker u_hrds_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[bench/hid_report_descriptor_scan_unit_tb.sv]
// Self-checking testbench for the HID report descriptor scan unit.
`timescale 1ns / 1ps

module hid_report_descriptor_scan_unit_tb;

   localparam int DEPTH_BITS      = hrds_pkg::DEPTH_BITS_DEFAULT;
   localparam int DATA_BITS       = hrds_pkg::RSP_DATA_BITS;
   localparam int CYCLE_LIMIT     = 500000;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int RANDOM_BYTES    = 1750;
   localparam int SETTLE_CYCLES   = 8;
   localparam int MAX_IDLE        = 16;

   typedef enum logic [1:0] {
      SCAN_PREFIX,
      SCAN_DATA,
      SCAN_LONG_LEN,
      SCAN_LONG_SKIP
   } scan_phase_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = '0;   // data_byte
   logic                 req_tlast  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   // top_page[15:0], usage[31:16], has_report_ids[32], truncated[33], zero fill
   logic [DATA_BITS-1:0] rsp_tdata;

   hid_report_descriptor_scan_unit #(
      .DEPTH_BITS(DEPTH_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   int   cycle_count  = 0;
   int   error_count  = 0;
   int   bytes_sent   = 0;
   logic no_idle      = 1'b0;
   logic rsp_hold_req = 1'b0;

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** hid_report_descriptor_scan_unit: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor
   scan_phase_type            scan_phase;
   logic [8:0]                scan_left;
   logic [7:0]                scan_tag;
   logic [2:0]                scan_size;
   logic [15:0]               scan_value;
   logic [DEPTH_BITS-1:0]     scan_depth;
   logic [15:0]               top_page_seen;
   logic [15:0]               top_usage;
   logic                      saw_report_id;
   hrds_pkg::hrds_result_type summary_q[$];

   function automatic void clear_scan();
      scan_phase    = SCAN_PREFIX;
      scan_left     = '0;
      scan_tag      = '0;
      scan_size     = '0;
      scan_value    = '0;
      scan_depth    = '0;
      top_page_seen = '0;
      top_usage     = '0;
      saw_report_id = 1'b0;
   endfunction

   function automatic void apply_item();
      unique case (scan_tag)
         hrds_pkg::TAG_COLLECTION: scan_depth = scan_depth + 1'b1;
         hrds_pkg::TAG_END_COLL:   scan_depth = scan_depth - 1'b1;
         hrds_pkg::TAG_REPORT_ID:  saw_report_id = 1'b1;
         hrds_pkg::TAG_USAGE_PAGE: if (scan_depth == '0) top_page_seen = scan_value;
         hrds_pkg::TAG_USAGE:      if (scan_depth == '0) top_usage = scan_value;
         default: ;
      endcase
   endfunction

   function automatic void scan_byte(input logic [7:0] b, input logic is_last);
      hrds_pkg::hrds_result_type summary;
      logic [2:0]                pos;
      case (scan_phase)
         SCAN_PREFIX: begin
            if (b == hrds_pkg::LONG_PREFIX) begin
               scan_phase = SCAN_LONG_LEN;
            end else begin
               scan_size  = (b[1:0] == 2'd3) ? 3'd4 : {1'b0, b[1:0]};
               scan_tag   = b & hrds_pkg::TAG_MASK;
               scan_value = '0;
               if (scan_size == 3'd0) begin
                  apply_item();
               end else begin
                  scan_left  = {6'd0, scan_size};
                  scan_phase = SCAN_DATA;
               end
            end
         end
         SCAN_DATA: begin
            // only the first two data bytes land in the value
            pos = scan_size - scan_left[2:0];
            if (pos == 3'd0) scan_value = scan_value | {8'h00, b};
            else if (pos == 3'd1) scan_value = scan_value | {b, 8'h00};
            if (scan_left != '0) scan_left = scan_left - 1'b1;
            if (scan_left == '0) begin
               apply_item();
               scan_phase = SCAN_PREFIX;
            end
         end
         SCAN_LONG_LEN: begin
            // tag byte plus the data bytes
            scan_left  = {1'b0, b} + 9'd1;
            scan_phase = SCAN_LONG_SKIP;
         end
         default: begin
            if (scan_left != '0) scan_left = scan_left - 1'b1;
            if (scan_left == '0) scan_phase = SCAN_PREFIX;
         end
      endcase
      if (is_last) begin
         summary.top_page       = top_page_seen;
         summary.usage          = top_usage;
         summary.has_report_ids = saw_report_id;
         summary.truncated      = (scan_phase == SCAN_DATA);
         summary_q.push_back(summary);
         clear_scan();
      end
   endfunction

   // ---------------------------------------------------------------- checker
   function automatic void flag_mismatch(input string field,
                                         input logic [DATA_BITS-1:0] want,
                                         input logic [DATA_BITS-1:0] got);
      error_count = error_count + 1;
      if (error_count <= 10)
         $display("mismatch (%s) at cycle %0d: expected %h, got %h",
                  field, cycle_count, want, got);
   endfunction

   function automatic void check_summary(input logic [DATA_BITS-1:0] d);
      hrds_pkg::hrds_result_type want;
      if (summary_q.size() == 0) begin
         flag_mismatch("item with none expected", '0, d);
      end else begin
         want = summary_q.pop_front();
         if (d[15:0] !== want.top_page)
            flag_mismatch("top_page", DATA_BITS'(want.top_page), DATA_BITS'(d[15:0]));
         if (d[31:16] !== want.usage)
            flag_mismatch("usage", DATA_BITS'(want.usage), DATA_BITS'(d[31:16]));
         if (d[32] !== want.has_report_ids)
            flag_mismatch("has_report_ids", DATA_BITS'(want.has_report_ids),
                          DATA_BITS'(d[32]));
         if (d[33] !== want.truncated)
            flag_mismatch("truncated", DATA_BITS'(want.truncated), DATA_BITS'(d[33]));
         if (d[DATA_BITS-1:34] !== '0)
            flag_mismatch("zero fill", '0, DATA_BITS'(d[DATA_BITS-1:34]));
      end
   endfunction

   // result side: random stalls, bursts without stalls, and a long hold on request
   int rsp_stall = 0;
   int rsp_burst = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_summary(rsp_tdata);
            if (rsp_burst > 0) begin
               rsp_burst = rsp_burst - 1;
               rsp_stall = 0;
            end else begin
               rsp_stall = $urandom_range(0, MAX_IDLE);
               if ($urandom_range(0, 7) == 0) rsp_burst = $urandom_range(4, 20);
            end
         end else if (rsp_stall > 0) begin
            rsp_stall = rsp_stall - 1;
         end
         if (rsp_hold_req) begin
            rsp_stall = RSP_HOLD_CYCLES;
            rsp_hold_req <= 1'b0;
         end
         rsp_tready <= (rsp_stall == 0);
      end
   end

   // ---------------------------------------------------------------- stimulus
   logic [7:0] desc_bytes[$];

   task automatic send_byte(input logic [7:0] b, input logic is_last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      scan_byte(b, is_last);
      bytes_sent = bytes_sent + 1;
   endtask

   task automatic send_descriptor();
      for (int i = 0; i < desc_bytes.size(); i++)
         send_byte(desc_bytes[i], i == desc_bytes.size() - 1);
   endtask

   // sender pauses until every summary is back
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (summary_q.size() != 0) @(posedge clock);
   endtask

   function automatic void add_short(input logic [7:0] prefix);
      int n;
      n = (prefix[1:0] == 2'd3) ? 4 : int'(prefix[1:0]);
      desc_bytes.push_back(prefix);
      repeat (n) desc_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void add_long();
      int len;
      len = ($urandom_range(0, 39) == 0) ? 255 : $urandom_range(0, 4);
      desc_bytes.push_back(hrds_pkg::LONG_PREFIX);
      desc_bytes.push_back(8'(len));
      desc_bytes.push_back(8'($urandom_range(0, 255)));
      repeat (len) desc_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void build_descriptor();
      int         open_coll;
      int         cut;
      int         pick;
      logic [7:0] sz;
      logic [7:0] prefix;
      desc_bytes.delete();
      open_coll = 0;
      repeat ($urandom_range(1, 8)) begin
         sz   = 8'($urandom_range(0, 3));
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1: add_short(hrds_pkg::TAG_USAGE_PAGE | sz);
            2, 3: add_short(hrds_pkg::TAG_USAGE | sz);
            4: begin
               add_short(hrds_pkg::TAG_COLLECTION | sz);
               open_coll = open_coll + 1;
            end
            5: begin
               add_short(hrds_pkg::TAG_END_COLL | sz);
               if (open_coll > 0) open_coll = open_coll - 1;
            end
            6: add_short(hrds_pkg::TAG_REPORT_ID | sz);
            7: add_long();
            default: begin
               prefix = 8'($urandom_range(0, 255));
               if (prefix == hrds_pkg::LONG_PREFIX) add_long();
               else add_short(prefix);
            end
         endcase
      end
      if ($urandom_range(0, 9) < 7)
         repeat (open_coll) desc_bytes.push_back(hrds_pkg::TAG_END_COLL);
      pick = $urandom_range(0, 99);
      if (pick < 15 && desc_bytes.size() > 1) begin
         // end the descriptor early, possibly inside an item
         cut = $urandom_range(1, desc_bytes.size() - 1);
         while (desc_bytes.size() > cut) void'(desc_bytes.pop_back());
      end else if (pick < 20) begin
         desc_bytes.delete();
         repeat ($urandom_range(1, 12)) desc_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   // ---------------------------------------------------------------- tests
   task automatic test_extreme_bytes();
      desc_bytes = '{8'h00};
      send_descriptor();
      desc_bytes = '{8'hFF};                       // short prefix cut off at once
      send_descriptor();
      desc_bytes = '{hrds_pkg::LONG_PREFIX};       // long item cut off, not flagged
      send_descriptor();
   endtask

   task automatic test_top_level_capture();
      desc_bytes = '{8'h05, 8'h01, 8'h0A, 8'hFF, 8'hFF};
      send_descriptor();
      // usage inside the collection is ignored; four-byte page after it counts
      desc_bytes = '{8'hA1, 8'h01, 8'h09, 8'h33, 8'h85, 8'h01, 8'hC0,
                     8'h07, 8'h34, 8'h12, 8'hAB, 8'hCD};
      send_descriptor();
   endtask

   task automatic test_depth_wrap();
      desc_bytes = '{8'hC0, 8'h09, 8'h05};
      send_descriptor();
   endtask

   task automatic test_truncated_short();
      desc_bytes = '{8'h05, 8'h01, 8'h06};
      send_descriptor();
   endtask

   task automatic test_long_items();
      desc_bytes = '{hrds_pkg::LONG_PREFIX, 8'h02, 8'h12, 8'h05, 8'h09, 8'h09, 8'h07};
      send_descriptor();
   endtask

   task automatic test_output_backpressure();
      rsp_hold_req <= 1'b1;
      no_idle = 1'b1;
      repeat (8) begin
         desc_bytes.delete();
         add_short(hrds_pkg::TAG_USAGE | 8'h01);
         send_descriptor();
      end
      no_idle = 1'b0;
   endtask

   task automatic test_random_descriptors();
      int start;
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_BYTES) begin
         no_idle = ($urandom_range(0, 4) == 0);
         build_descriptor();
         send_descriptor();
         if ($urandom_range(0, 15) == 0) wait_for_drain();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      clear_scan();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_extreme_bytes();
      test_top_level_capture();
      test_depth_wrap();
      test_truncated_short();
      test_long_items();
      wait_for_drain();
      test_output_backpressure();
      wait_for_drain();
      test_random_descriptors();
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("** hid_report_descriptor_scan_unit: PASSED **");
      end else begin
         $display("** hid_report_descriptor_scan_unit: FAILED **");
      end
      $finish;
   end

endmodule

[files.f]
rtl/hrds_pkg.sv
rtl/hrds_parse_core.sv
rtl/hid_report_descriptor_scan_unit.sv
rtl/hrds_checker.sv
bench/hid_report_descriptor_scan_unit_tb.sv
